/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the channel mixer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed: next-cycle implication");

`endif

/* rtl/cmm_pkg.sv */
// ---------------------------------------------------------------------------
// Channel mixer package
// Types, field widths and codes shared by the mixer and its serial ALU.
// ---------------------------------------------------------------------------
package cmm_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W     = 24;
    localparam int FRAC_W       = 16;
    localparam int CH_W         = 3;
    localparam int MAX_IN       = 8;
    localparam int MAX_OUT      = 8;
    localparam int IDX_W        = 2 * CH_W;
    localparam int MIX_DEPTH    = MAX_IN * MAX_OUT;
    localparam int CNT_CFG_W    = 4;
    localparam int FRAMES_CFG_W = 13;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int ACC_W        = 48;
    localparam int GAIN_W       = 33;
    localparam int DIFF_W       = 34;
    localparam int MUL_W        = 64;
    localparam int DIVISOR_W    = 17;
    localparam int DIV_STEPS    = 50;
    localparam int STEP_W       = 6;

    localparam logic signed [SAMPLE_W-1:0] UNITY_GAIN = SAMPLE_W'(1 << FRAC_W);

    // Commands
    localparam logic [1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [1:0] CMD_MIX_GAIN = 2'd1;
    localparam logic [1:0] CMD_OUT_GAIN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES       = 2'd2;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [CH_W-1:0]            in_channel;
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] value;
        logic                       fade;
        logic                       frame_end;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]            out_index;
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       clipped;
        logic                       last;
    } out_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL0,
        ST_WAIT0,
        ST_MUL1,
        ST_WAIT1,
        ST_MULK,
        ST_WAITK,
        ST_DIV,
        ST_WAITD,
        ST_MULV,
        ST_WAITV,
        ST_ACC,
        ST_EMIT,
        ST_EMITW,
        ST_CLOSE
    } state_t;

endpackage

/* rtl/cmm_alu.sv */
// ---------------------------------------------------------------------------
// Serial arithmetic unit
// Bit-serial signed multiply (one multiplier bit per cycle) and restoring
// signed divide (one quotient bit per cycle, truncating toward zero).
// ---------------------------------------------------------------------------
module cmm_alu (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmm_pkg::alu_ctl_t                    ctl,
    input  logic signed [cmm_pkg::MUL_W-1:0]     opa,
    input  logic signed [cmm_pkg::SAMPLE_W-1:0]  opb,
    input  logic [cmm_pkg::DIVISOR_W-1:0]        divisor,
    output logic                                 done,
    output logic signed [cmm_pkg::MUL_W-1:0]     result
);

    logic                                  busy_reg;
    logic                                  fin_reg;
    logic                                  done_reg;
    cmm_pkg::alu_op_t                      op_reg;
    logic [cmm_pkg::STEP_W-1:0]            cnt_reg;
    logic signed [cmm_pkg::MUL_W-1:0]      acc_reg;
    logic signed [cmm_pkg::MUL_W-1:0]      mcand_reg;
    logic [cmm_pkg::SAMPLE_W-1:0]          mplier_reg;
    logic                                  neg_reg;
    logic [cmm_pkg::MUL_W-1:0]             dvd_reg;
    logic [cmm_pkg::DIVISOR_W-1:0]         dsr_reg;
    logic [cmm_pkg::DIVISOR_W-1:0]         rem_reg;
    logic signed [cmm_pkg::MUL_W-1:0]      result_reg;

    logic signed [cmm_pkg::MUL_W-1:0]      mul_add;
    logic signed [cmm_pkg::MUL_W-1:0]      acc_mul;
    logic [cmm_pkg::DIVISOR_W:0]           rem_shift;
    logic                                  rem_ge;
    logic [cmm_pkg::DIVISOR_W:0]           rem_sub;
    logic [cmm_pkg::MUL_W-1:0]             mag;
    logic                                  last_step;

    // One step of either operation
    always_comb
    begin
        if (mplier_reg[0])
        begin
            if (cnt_reg == cmm_pkg::STEP_W'(cmm_pkg::SAMPLE_W - 1))
                mul_add = -mcand_reg;   // sign bit carries negative weight
            else
                mul_add = mcand_reg;
        end
        else
        begin
            mul_add = '0;
        end
        acc_mul   = acc_reg + mul_add;
        rem_shift = {rem_reg, dvd_reg[cmm_pkg::DIV_STEPS-1]};
        rem_ge    = rem_shift >= {1'b0, dsr_reg};
        rem_sub   = rem_ge ? rem_shift - {1'b0, dsr_reg} : rem_shift;
        mag       = opa[cmm_pkg::MUL_W-1] ? -opa : opa;
        if (op_reg == cmm_pkg::ALU_MUL)
            last_step = cnt_reg == cmm_pkg::STEP_W'(cmm_pkg::SAMPLE_W - 1);
        else
            last_step = cnt_reg == cmm_pkg::STEP_W'(cmm_pkg::DIV_STEPS - 1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= cmm_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && last_step;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + cmm_pkg::STEP_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= opa;
            mplier_reg <= opb;
            neg_reg    <= opa[cmm_pkg::MUL_W-1];
            dvd_reg    <= mag;
            dsr_reg    <= divisor;
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == cmm_pkg::ALU_MUL)
            begin
                acc_reg    <= acc_mul;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            else
            begin
                rem_reg <= rem_sub[cmm_pkg::DIVISOR_W-1:0];
                dvd_reg <= dvd_reg << 1;
                acc_reg <= {acc_reg[cmm_pkg::MUL_W-2:0], rem_ge};
            end
        end
        if (fin_reg)
            result_reg <= (op_reg == cmm_pkg::ALU_DIV && neg_reg) ? -acc_reg : acc_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/channel_mix_matrix_gain_fade.sv */
// ---------------------------------------------------------------------------
// Channel mix matrix with gain fade
// Input-by-output gain matrix with master gain and linear per-block fades;
// accumulates weighted samples and emits saturated outputs at frame end.
//
//   channel  | signals                          | when taken
//   ---------+----------------------------------+---------------------------
//   input    | in_valid / in_ready / in_data    | valid & ready at clk rise
//   output   | out_valid / out_ready / out_data | valid & ready at clk rise
//   config   | cfg_we / cfg_index / cfg_data    | cfg_we at clk rise
//
// Every item is accepted from idle; gain commands end there.
// A sample item walks the active output channels one by one through the
// shared bit-serial ALU: read, two multiplies (each a start, 24 steps and
// a hand-over), on every frame of a block but the first a k multiply and
// a 50-step divide, then the sample multiply and the accumulate step.
// Frame end then emits each result in turn and closes the frame.
// Input is taken only in idle; out_ready stalls hold the sequencer.
// Reset restores master gain, flags, accumulators, config and state at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module channel_mix_matrix_gain_fade #(
    parameter int MAX_FRAMES_PER_BLOCK = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmm_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cmm_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmm_pkg::CFG_W-1:0]      cfg_data
);

    localparam int KW = (MAX_FRAMES_PER_BLOCK > 1) ? $clog2(MAX_FRAMES_PER_BLOCK) : 1;
    localparam int MW = cmm_pkg::MUL_W;
    localparam logic [cmm_pkg::DIVISOR_W-1:0] MAXF =
        cmm_pkg::DIVISOR_W'(MAX_FRAMES_PER_BLOCK);
    localparam logic signed [MW-1:0] ACC_HI =
        {{(MW - cmm_pkg::ACC_W + 1){1'b0}}, {(cmm_pkg::ACC_W - 1){1'b1}}};
    localparam logic signed [MW-1:0] ACC_LO =
        {{(MW - cmm_pkg::ACC_W + 1){1'b1}}, {(cmm_pkg::ACC_W - 1){1'b0}}};
    localparam logic signed [cmm_pkg::ACC_W-1:0] SMP_HI =
        {{(cmm_pkg::ACC_W - cmm_pkg::SAMPLE_W + 1){1'b0}}, {(cmm_pkg::SAMPLE_W - 1){1'b1}}};
    localparam logic signed [cmm_pkg::ACC_W-1:0] SMP_LO =
        {{(cmm_pkg::ACC_W - cmm_pkg::SAMPLE_W + 1){1'b1}}, {(cmm_pkg::SAMPLE_W - 1){1'b0}}};

    // Round half up from Q.16 to integer part
    function automatic logic signed [MW-1:0] round_q(input logic signed [MW-1:0] x);
        logic signed [MW-1:0] half;
        half = MW'(1) <<< (cmm_pkg::FRAC_W - 1);
        return (x + half) >>> cmm_pkg::FRAC_W;
    endfunction

    cmm_pkg::state_t                        state_reg, state_next;

    // Configuration
    logic [cmm_pkg::CNT_CFG_W-1:0]          in_ch_reg;
    logic [cmm_pkg::CNT_CFG_W-1:0]          out_ch_reg;
    logic [cmm_pkg::FRAMES_CFG_W-1:0]       frames_reg;

    // Gain state
    logic signed [cmm_pkg::SAMPLE_W-1:0]    master_gain_reg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    master_next_reg;
    logic                                   master_fade_reg;
    logic [cmm_pkg::MIX_DEPTH-1:0]          sel_reg;
    logic [cmm_pkg::MIX_DEPTH-1:0]          fad_reg;
    logic [cmm_pkg::MIX_DEPTH-1:0]          v0_reg;
    logic [cmm_pkg::MIX_DEPTH-1:0]          v1_reg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    mem0 [cmm_pkg::MIX_DEPTH];
    logic signed [cmm_pkg::SAMPLE_W-1:0]    mem1 [cmm_pkg::MIX_DEPTH];
    logic [KW-1:0]                          frame_idx_reg;
    logic signed [cmm_pkg::ACC_W-1:0]       accum_reg [cmm_pkg::MAX_OUT];

    // Working item
    logic [cmm_pkg::CH_W-1:0]               o_reg;
    logic [cmm_pkg::CH_W-1:0]               ic_reg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    value_reg;
    logic                                   fend_reg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    rd0_reg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    rd1_reg;
    logic                                   rv0_reg;
    logic                                   rv1_reg;
    logic                                   rsel_reg;
    logic                                   rfad_reg;
    logic signed [cmm_pkg::GAIN_W-1:0]      g0_reg;
    logic signed [cmm_pkg::GAIN_W-1:0]      g1_reg;
    logic signed [cmm_pkg::GAIN_W-1:0]      g_reg;
    logic                                   out_valid_reg;
    cmm_pkg::out_t                          out_data_reg;

    // Derived signals
    logic [cmm_pkg::CNT_CFG_W-1:0]          nin;
    logic [cmm_pkg::CNT_CFG_W-1:0]          nout;
    logic [cmm_pkg::DIVISOR_W-1:0]          fr_ext;
    logic [cmm_pkg::DIVISOR_W-1:0]          nfr;
    logic [cmm_pkg::DIVISOR_W-1:0]          fi_ext;
    logic [cmm_pkg::DIVISOR_W-1:0]          fi_inc;
    logic [cmm_pkg::DIVISOR_W-1:0]          k_full;
    logic [KW-1:0]                          k;
    logic                                   block_end;
    logic [cmm_pkg::CNT_CFG_W-1:0]          o_inc;
    logic                                   o_more;
    logic                                   o_last;
    logic                                   in_fire;
    logic                                   in_ok;
    logic                                   mix_wr;
    logic [cmm_pkg::IDX_W-1:0]              wr_idx;
    logic [cmm_pkg::IDX_W-1:0]              rd_idx;
    logic                                   wr_slot;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    d0;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    d1;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    mg;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    mn;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    mend;
    logic signed [cmm_pkg::DIFF_W-1:0]      diff;
    logic signed [MW-1:0]                   acc_sum;
    logic signed [cmm_pkg::ACC_W-1:0]       acc_sat;
    logic signed [cmm_pkg::ACC_W-1:0]       acc_cur;

    // ALU interface
    cmm_pkg::alu_ctl_t                      alu_ctl;
    logic signed [MW-1:0]                   alu_opa;
    logic signed [cmm_pkg::SAMPLE_W-1:0]    alu_opb;
    logic                                   alu_done;
    logic signed [MW-1:0]                   alu_result;

    cmm_alu u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (alu_ctl),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .divisor (nfr),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Clamped counts, ramp position and channel walk
    always_comb
    begin
        if (in_ch_reg == '0)
            nin = cmm_pkg::CNT_CFG_W'(1);
        else if (in_ch_reg > cmm_pkg::CNT_CFG_W'(cmm_pkg::MAX_IN))
            nin = cmm_pkg::CNT_CFG_W'(cmm_pkg::MAX_IN);
        else
            nin = in_ch_reg;
        if (out_ch_reg == '0)
            nout = cmm_pkg::CNT_CFG_W'(1);
        else if (out_ch_reg > cmm_pkg::CNT_CFG_W'(cmm_pkg::MAX_OUT))
            nout = cmm_pkg::CNT_CFG_W'(cmm_pkg::MAX_OUT);
        else
            nout = out_ch_reg;
        fr_ext = cmm_pkg::DIVISOR_W'(frames_reg);
        if (fr_ext == '0)
            nfr = cmm_pkg::DIVISOR_W'(1);
        else if (fr_ext > MAXF)
            nfr = MAXF;
        else
            nfr = fr_ext;
        fi_ext    = cmm_pkg::DIVISOR_W'(frame_idx_reg);
        fi_inc    = fi_ext + cmm_pkg::DIVISOR_W'(1);
        k_full    = (fi_ext < nfr) ? fi_ext : nfr - cmm_pkg::DIVISOR_W'(1);
        k         = k_full[KW-1:0];
        block_end = fi_inc >= nfr;
        o_inc     = {1'b0, o_reg} + cmm_pkg::CNT_CFG_W'(1);
        o_more    = o_inc < nout;
        o_last    = o_inc == nout;
    end

    // Command decode and gain selection
    always_comb
    begin
        in_fire = in_valid && in_ready;
        in_ok   = {1'b0, in_data.in_channel} < nin;
        mix_wr  = in_fire && in_data.cmd == cmm_pkg::CMD_MIX_GAIN && in_ok
                  && ({1'b0, in_data.out_channel} < nout);
        wr_idx  = {in_data.in_channel, in_data.out_channel};
        rd_idx  = {ic_reg, o_reg};
        // a fade writes the slot that is not current
        wr_slot = in_data.fade ? ~sel_reg[wr_idx] : sel_reg[wr_idx];
        d0      = rv0_reg ? rd0_reg : '0;
        d1      = rv1_reg ? rd1_reg : '0;
        mg      = rsel_reg ? d1 : d0;
        mn      = rfad_reg ? (rsel_reg ? d0 : d1) : mg;
        mend    = master_fade_reg ? master_next_reg : master_gain_reg;
        diff    = cmm_pkg::DIFF_W'(g1_reg) - cmm_pkg::DIFF_W'(g0_reg);
        acc_cur = accum_reg[o_reg];
        acc_sum = MW'(acc_cur) + round_q(alu_result);
        if (acc_sum > ACC_HI)
            acc_sat = ACC_HI[cmm_pkg::ACC_W-1:0];
        else if (acc_sum < ACC_LO)
            acc_sat = ACC_LO[cmm_pkg::ACC_W-1:0];
        else
            acc_sat = acc_sum[cmm_pkg::ACC_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmm_pkg::ST_IDLE:
            begin
                if (in_fire && in_data.cmd == cmm_pkg::CMD_SAMPLE)
                begin
                    if (in_ok)
                        state_next = cmm_pkg::ST_READ;
                    else if (in_data.frame_end)
                        state_next = cmm_pkg::ST_EMIT;
                end
            end
            cmm_pkg::ST_READ:  state_next = cmm_pkg::ST_MUL0;
            cmm_pkg::ST_MUL0:  state_next = cmm_pkg::ST_WAIT0;
            cmm_pkg::ST_WAIT0:
            begin
                if (alu_done)
                    state_next = cmm_pkg::ST_MUL1;
            end
            cmm_pkg::ST_MUL1:  state_next = cmm_pkg::ST_WAIT1;
            cmm_pkg::ST_WAIT1:
            begin
                if (alu_done)
                    state_next = (k == '0) ? cmm_pkg::ST_MULV : cmm_pkg::ST_MULK;
            end
            cmm_pkg::ST_MULK:  state_next = cmm_pkg::ST_WAITK;
            cmm_pkg::ST_WAITK:
            begin
                if (alu_done)
                    state_next = cmm_pkg::ST_DIV;
            end
            cmm_pkg::ST_DIV:   state_next = cmm_pkg::ST_WAITD;
            cmm_pkg::ST_WAITD:
            begin
                if (alu_done)
                    state_next = cmm_pkg::ST_MULV;
            end
            cmm_pkg::ST_MULV:  state_next = cmm_pkg::ST_WAITV;
            cmm_pkg::ST_WAITV:
            begin
                if (alu_done)
                    state_next = cmm_pkg::ST_ACC;
            end
            cmm_pkg::ST_ACC:
            begin
                if (o_more)
                    state_next = cmm_pkg::ST_READ;
                else if (fend_reg)
                    state_next = cmm_pkg::ST_EMIT;
                else
                    state_next = cmm_pkg::ST_IDLE;
            end
            cmm_pkg::ST_EMIT:  state_next = cmm_pkg::ST_EMITW;
            cmm_pkg::ST_EMITW:
            begin
                if (out_ready)
                    state_next = out_data_reg.last ? cmm_pkg::ST_CLOSE : cmm_pkg::ST_EMIT;
            end
            cmm_pkg::ST_CLOSE: state_next = cmm_pkg::ST_IDLE;
            default:           state_next = cmm_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake and ALU operands
    always_comb
    begin
        in_ready      = state_reg == cmm_pkg::ST_IDLE;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = cmm_pkg::ALU_MUL;
        alu_opa       = '0;
        alu_opb       = '0;
        unique case (state_reg)
            cmm_pkg::ST_MUL0:
            begin
                alu_ctl.start = 1'b1;
                alu_opa       = MW'(master_gain_reg);
                alu_opb       = mg;
            end
            cmm_pkg::ST_MUL1:
            begin
                alu_ctl.start = 1'b1;
                alu_opa       = MW'(mend);
                alu_opb       = mn;
            end
            cmm_pkg::ST_MULK:
            begin
                alu_ctl.start = 1'b1;
                alu_opa       = MW'(diff);
                alu_opb       = $signed(cmm_pkg::SAMPLE_W'(k));
            end
            cmm_pkg::ST_DIV:
            begin
                alu_ctl.start = 1'b1;
                alu_ctl.op    = cmm_pkg::ALU_DIV;
                alu_opa       = alu_result;
            end
            cmm_pkg::ST_MULV:
            begin
                alu_ctl.start = 1'b1;
                alu_opa       = MW'(g_reg);
                alu_opb       = value_reg;
            end
            default:
            begin
                alu_ctl.start = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cmm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= cmm_pkg::CNT_CFG_W'(2);
            out_ch_reg <= cmm_pkg::CNT_CFG_W'(2);
            frames_reg <= cmm_pkg::FRAMES_CFG_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmm_pkg::CFG_IN_CHANNELS:  in_ch_reg  <= cfg_data[cmm_pkg::CNT_CFG_W-1:0];
                cmm_pkg::CFG_OUT_CHANNELS: out_ch_reg <= cfg_data[cmm_pkg::CNT_CFG_W-1:0];
                cmm_pkg::CFG_FRAMES:       frames_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Gain flags, master gain, frame count, accumulators and output item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_gain_reg <= cmm_pkg::UNITY_GAIN;
            master_next_reg <= '0;
            master_fade_reg <= 1'b0;
            sel_reg         <= '0;
            fad_reg         <= '0;
            v0_reg          <= '0;
            v1_reg          <= '0;
            frame_idx_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < cmm_pkg::MAX_OUT; i++)
                accum_reg[i] <= '0;
        end
        else
        begin
            // gain commands
            if (mix_wr)
            begin
                fad_reg[wr_idx] <= in_data.fade;
                if (wr_slot)
                    v1_reg[wr_idx] <= 1'b1;
                else
                    v0_reg[wr_idx] <= 1'b1;
            end
            if (in_fire && in_data.cmd == cmm_pkg::CMD_OUT_GAIN)
            begin
                master_fade_reg <= in_data.fade;
                if (in_data.fade)
                    master_next_reg <= in_data.value;
                else
                    master_gain_reg <= in_data.value;
            end
            // accumulate one output channel
            if (state_reg == cmm_pkg::ST_ACC)
                accum_reg[o_reg] <= acc_sat;
            // output item register
            if (state_reg == cmm_pkg::ST_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            // frame close: clear, advance, commit fades at block end
            if (state_reg == cmm_pkg::ST_CLOSE)
            begin
                for (int i = 0; i < cmm_pkg::MAX_OUT; i++)
                    accum_reg[i] <= '0;
                if (block_end)
                begin
                    frame_idx_reg <= '0;
                    sel_reg       <= sel_reg ^ fad_reg;
                    fad_reg       <= '0;
                    if (master_fade_reg)
                    begin
                        master_gain_reg <= master_next_reg;
                        master_fade_reg <= 1'b0;
                    end
                end
                else
                begin
                    frame_idx_reg <= fi_inc[KW-1:0];
                end
            end
        end
    end

    // Gain memories, two slots per matrix entry
    always_ff @(posedge clk)
    begin
        if (mix_wr && !wr_slot)
            mem0[wr_idx] <= in_data.value;
        if (state_reg == cmm_pkg::ST_READ)
            rd0_reg <= mem0[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (mix_wr && wr_slot)
            mem1[wr_idx] <= in_data.value;
        if (state_reg == cmm_pkg::ST_READ)
            rd1_reg <= mem1[rd_idx];
    end

    // Working item datapath
    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.cmd == cmm_pkg::CMD_SAMPLE)
        begin
            ic_reg    <= in_data.in_channel;
            value_reg <= in_data.value;
            fend_reg  <= in_data.frame_end;
            o_reg     <= '0;
        end
        if (state_reg == cmm_pkg::ST_READ)
        begin
            rv0_reg  <= v0_reg[rd_idx];
            rv1_reg  <= v1_reg[rd_idx];
            rsel_reg <= sel_reg[rd_idx];
            rfad_reg <= fad_reg[rd_idx];
        end
        if (state_reg == cmm_pkg::ST_WAIT0 && alu_done)
            g0_reg <= cmm_pkg::GAIN_W'(round_q(alu_result));
        if (state_reg == cmm_pkg::ST_WAIT1 && alu_done)
        begin
            g1_reg <= cmm_pkg::GAIN_W'(round_q(alu_result));
            g_reg  <= g0_reg;
        end
        if (state_reg == cmm_pkg::ST_WAITD && alu_done)
            g_reg <= g0_reg + alu_result[cmm_pkg::GAIN_W-1:0];
        if (state_reg == cmm_pkg::ST_ACC)
        begin
            if (o_more)
                o_reg <= o_reg + cmm_pkg::CH_W'(1);
            else
                o_reg <= '0;
        end
        if (state_reg == cmm_pkg::ST_EMITW && out_ready)
            o_reg <= o_reg + cmm_pkg::CH_W'(1);
        if (state_reg == cmm_pkg::ST_EMIT)
        begin
            out_data_reg.out_index <= o_reg;
            out_data_reg.last      <= o_last;
            if (acc_cur > SMP_HI)
            begin
                out_data_reg.out_sample <= SMP_HI[cmm_pkg::SAMPLE_W-1:0];
                out_data_reg.clipped    <= 1'b1;
            end
            else if (acc_cur < SMP_LO)
            begin
                out_data_reg.out_sample <= SMP_LO[cmm_pkg::SAMPLE_W-1:0];
                out_data_reg.clipped    <= 1'b1;
            end
            else
            begin
                out_data_reg.out_sample <= acc_cur[cmm_pkg::SAMPLE_W-1:0];
                out_data_reg.clipped    <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `CMM_ASSERT_IMP(a_idle_no_output, clk, rst_n, in_ready, !out_valid)
    `CMM_ASSERT_NXT(a_last_ends_frame, clk, rst_n, out_valid && out_ready && out_data.last, !out_valid)
    `CMM_ASSERT_IMP(a_index_in_use, clk, rst_n, out_valid, ({1'b0, out_data.out_index} < nout))

endmodule
